>>> rtl/core/lud_pkg.sv
// Shared types, constants and fixed-point helpers for the lens point undistorter.
// No dependencies; used by lud_div.sv, lens_undistort_point.sv, lud_checker.sv and the test top.
`default_nettype none

package lud_pkg;

    localparam int ITERATIONS = 5;        // refinement passes
    localparam int NUM_W      = 61;       // dividend magnitude, Q28 shifted
    localparam int DEN_W      = 37;       // divisor magnitude
    localparam int DIV_STEPS  = 32;       // quotient bits, one per stage

    localparam logic signed [39:0] S32_MAX40 = 40'sd2147483647;
    localparam logic signed [39:0] S32_MIN40 = -40'sd2147483648;
    localparam logic signed [39:0] ONE_Q28   = 40'sd268435456;

    typedef enum logic [2:0] {
        CFG_FOCAL_X = 3'd0,
        CFG_FOCAL_Y = 3'd1,
        CFG_CENTER_X = 3'd2,
        CFG_CENTER_Y = 3'd3,
        CFG_RADIAL_K1 = 3'd4,
        CFG_RADIAL_K2 = 3'd5,
        CFG_TANG_P1 = 3'd6,
        CFG_TANG_P2 = 3'd7
    } t_cfg_idx;

    // Per-point state carried along the pipeline.
    typedef struct packed {
        logic signed [31:0] x0;
        logic signed [31:0] y0;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic               flag;
        logic               done;   // a denominator failed, later passes hold x, y
    } t_side;

    typedef struct packed {
        logic               neg_x;
        logic               neg_y;
        logic [NUM_W-1:0]   num_x;
        logic [NUM_W-1:0]   num_y;
        logic [DEN_W-1:0]   den_x;
        logic [DEN_W-1:0]   den_y;
        t_side              side;
    } t_div_req;

    typedef struct packed {
        logic signed [31:0] q_x;
        logic signed [31:0] q_y;
        logic               sat_x;
        logic               sat_y;
        t_side              side;
    } t_div_rsp;

    // Q4.28 product, round half up.
    function automatic logic signed [36:0] qmul(input logic signed [32:0] a,
                                                input logic signed [32:0] b);
        logic signed [65:0] pr;
        pr = a * b;
        pr = pr + 66'sd134217728;
        return pr[64:28];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
        if (v > S32_MAX40) begin
            return 32'sh7fffffff;
        end else if (v < S32_MIN40) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic logic ovf32(input logic signed [39:0] v);
        return (v > S32_MAX40) || (v < S32_MIN40);
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/lud_if.sv
// Channel interfaces of the lens point undistorter: point, result and config write.
// Depends on nothing but plain logic types.
`default_nettype none

interface lud_point_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    modport source (output valid, output point_x, output point_y, input ready);
    modport sink   (input valid, input point_x, input point_y, output ready);
endinterface

interface lud_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] corrected_x;
    logic signed [31:0] corrected_y;
    logic               saturated;
    modport source (output valid, output corrected_x, output corrected_y,
                    output saturated, input ready);
    modport sink   (input valid, input corrected_x, input corrected_y,
                    input saturated, output ready);
endinterface

interface lud_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/lens_undistort_point.sv
// Lens point undistorter: pixel point in, Brown-Conrady inverse by fixed passes, pixel out.
// Depends on lud_pkg, lud_if (channels) and lud_div (pipelined divider).
//
// Usage:
//   i_pt  : distorted point requests (point_x, point_y, signed Q16.16).
//   o_res : corrected point (corrected_x, corrected_y, saturated flag).
//   i_cfg : register writes (index 0..7, 32-bit data), always ready; write
//           only while no point is in flight.
// Throughput: one point per cycle. The whole pipeline advances together
// whenever the output register is empty or being taken.
// Pipeline: each divider is 34 stages (entry, 32 quotient bits, result);
// each pass adds 4 stages of multiply/add plus the divider request register;
// normalization adds one request register; the pixel mapping adds a multiply
// stage and the output.
// Reset: all valid bits clear; registers return to 550/550/320/240 and zero
// distortion. When o_res stalls, every stage holds and i_pt.ready drops;
// nothing is lost or repeated.
`default_nettype none

module lens_undistort_point (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    lud_point_if.sink   i_pt,
    lud_result_if.source o_res,
    lud_cfg_if.sink     i_cfg
);

    localparam int ITER = lud_pkg::ITERATIONS;

    logic [31:0]        r_fx, r_fy, r_cx, r_cy;
    logic signed [31:0] r_k1, r_k2, r_p1, r_p2;

    logic w_adv;
    logic r_out_v;

    assign w_adv       = !r_out_v || o_res.ready;
    assign i_pt.ready  = w_adv;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fx <= 32'd36044800;
            r_fy <= 32'd36044800;
            r_cx <= 32'd20971520;
            r_cy <= 32'd15728640;
            r_k1 <= '0;
            r_k2 <= '0;
            r_p1 <= '0;
            r_p2 <= '0;
        end else if (i_cfg.valid) begin
            case (lud_pkg::t_cfg_idx'(i_cfg.index))
                lud_pkg::CFG_FOCAL_X:   r_fx <= i_cfg.data;
                lud_pkg::CFG_FOCAL_Y:   r_fy <= i_cfg.data;
                lud_pkg::CFG_CENTER_X:  r_cx <= i_cfg.data;
                lud_pkg::CFG_CENTER_Y:  r_cy <= i_cfg.data;
                lud_pkg::CFG_RADIAL_K1: r_k1 <= i_cfg.data;
                lud_pkg::CFG_RADIAL_K2: r_k2 <= i_cfg.data;
                lud_pkg::CFG_TANG_P1:   r_p1 <= i_cfg.data;
                lud_pkg::CFG_TANG_P2:   r_p2 <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // ---------------- normalization request ----------------
    logic signed [33:0] w_nd_x, w_nd_y;
    logic [33:0]        w_nm_x, w_nm_y;
    logic               w_fz_x, w_fz_y;
    lud_pkg::t_div_req  n_nreq;

    lud_pkg::t_div_req  w_req   [ITER+1];
    logic               w_req_v [ITER+1];
    lud_pkg::t_div_rsp  w_rsp   [ITER+1];
    logic               w_rsp_v [ITER+1];
    lud_pkg::t_side     w_cur   [ITER+1];

    always_comb begin
        w_nd_x = {{2{i_pt.point_x[31]}}, i_pt.point_x} - {2'b00, r_cx};
        w_nd_y = {{2{i_pt.point_y[31]}}, i_pt.point_y} - {2'b00, r_cy};
        w_nm_x = w_nd_x[33] ? 34'(-w_nd_x) : 34'(w_nd_x);
        w_nm_y = w_nd_y[33] ? 34'(-w_nd_y) : 34'(w_nd_y);
        w_fz_x = (r_fx == 32'd0);
        w_fz_y = (r_fy == 32'd0);
        n_nreq.neg_x = w_nd_x[33];
        n_nreq.neg_y = w_nd_y[33];
        // zero focal length: 0 / 1 gives the required zero coordinate
        n_nreq.num_x = w_fz_x ? '0 : {w_nm_x[32:0], 28'b0};
        n_nreq.num_y = w_fz_y ? '0 : {w_nm_y[32:0], 28'b0};
        n_nreq.den_x = w_fz_x ? lud_pkg::DEN_W'(1) : {5'b0, r_fx};
        n_nreq.den_y = w_fz_y ? lud_pkg::DEN_W'(1) : {5'b0, r_fy};
        n_nreq.side  = '0;
        n_nreq.side.flag = w_fz_x || w_fz_y;
    end

    lud_pkg::t_div_req r_nreq;
    logic              r_nv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nv <= 1'b0;
        end else if (w_adv) begin
            r_nv <= i_pt.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_nreq <= n_nreq;
        end
    end

    assign w_req[0]   = r_nreq;
    assign w_req_v[0] = r_nv;

    // ---------------- dividers and result merge ----------------
    for (genvar d = 0; d <= ITER; d++) begin : g_div
        lud_div u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_valid (w_req_v[d]),
            .i_req   (w_req[d]),
            .o_valid (w_rsp_v[d]),
            .o_rsp   (w_rsp[d])
        );

        if (d == 0) begin : g_norm
            always_comb begin
                w_cur[d]      = w_rsp[d].side;
                w_cur[d].x0   = w_rsp[d].q_x;
                w_cur[d].y0   = w_rsp[d].q_y;
                w_cur[d].x    = w_rsp[d].q_x;
                w_cur[d].y    = w_rsp[d].q_y;
                w_cur[d].flag = w_rsp[d].side.flag || w_rsp[d].sat_x || w_rsp[d].sat_y;
            end
        end else begin : g_upd
            always_comb begin
                w_cur[d] = w_rsp[d].side;
                if (!w_rsp[d].side.done) begin
                    w_cur[d].x    = w_rsp[d].q_x;
                    w_cur[d].y    = w_rsp[d].q_y;
                    w_cur[d].flag = w_rsp[d].side.flag || w_rsp[d].sat_x
                                 || w_rsp[d].sat_y;
                end
            end
        end
    end

    // ---------------- refinement passes ----------------
    for (genvar p = 0; p < ITER; p++) begin : g_pass
        // stage 1: squares and cross product
        logic signed [36:0] w_xx, w_yy, w_xy;
        lud_pkg::t_side     n_s1;
        logic               r1_v;
        lud_pkg::t_side     r1_s;
        logic signed [31:0] r1_xx, r1_yy, r1_xy;
        // stage 2: r2 and tangential cross terms
        logic signed [39:0] w_r2;
        lud_pkg::t_side     n_s2;
        logic               r2_v;
        lud_pkg::t_side     r2_s;
        logic signed [31:0] r2_xx, r2_yy, r2_r2;
        logic signed [36:0] r2_pxy1, r2_pxy2;
        // stage 3: r4, ax, ay, k1*r2
        logic signed [36:0] w_r4;
        logic signed [39:0] w_ax, w_ay;
        lud_pkg::t_side     n_s3;
        logic               r3_v;
        lud_pkg::t_side     r3_s;
        logic signed [31:0] r3_r4, r3_ax, r3_ay;
        logic signed [36:0] r3_k1r2, r3_pxy1, r3_pxy2;
        // stage 4: remaining products
        logic               r4_v;
        lud_pkg::t_side     r4_s;
        logic signed [36:0] r4_k1r2, r4_k2r4, r4_p2ax, r4_p1ay, r4_pxy1, r4_pxy2;
        // stage 5: denominator, offsets, division request
        logic signed [39:0] w_den, w_dx, w_dy;
        logic signed [31:0] w_dxs, w_dys;
        logic signed [32:0] w_nx, w_ny;
        logic [32:0]        w_mx, w_my;
        logic               w_bad;
        lud_pkg::t_div_req  n_req;
        lud_pkg::t_div_req  r5_req;
        logic               r5_v;

        always_comb begin
            w_xx = lud_pkg::qmul(33'(w_cur[p].x), 33'(w_cur[p].x));
            w_yy = lud_pkg::qmul(33'(w_cur[p].y), 33'(w_cur[p].y));
            w_xy = lud_pkg::qmul(33'(w_cur[p].x), 33'(w_cur[p].y));
            w_r2 = 40'(r1_xx) + 40'(r1_yy);
            w_r4 = lud_pkg::qmul(33'(r2_r2), 33'(r2_r2));
            w_ax = 40'(r2_r2) + 2 * 40'(r2_xx);
            w_ay = 40'(r2_r2) + 2 * 40'(r2_yy);

            n_s1      = w_cur[p];
            n_s1.flag = w_cur[p].flag || lud_pkg::ovf32(40'(w_xx))
                     || lud_pkg::ovf32(40'(w_yy)) || lud_pkg::ovf32(40'(w_xy));
            n_s2      = r1_s;
            n_s2.flag = r1_s.flag || lud_pkg::ovf32(w_r2);
            n_s3      = r2_s;
            n_s3.flag = r2_s.flag || lud_pkg::ovf32(40'(w_r4))
                     || lud_pkg::ovf32(w_ax) || lud_pkg::ovf32(w_ay);

            w_den = lud_pkg::ONE_Q28 + 40'(r4_k1r2) + 40'(r4_k2r4);
            w_dx  = 2 * 40'(r4_pxy1) + 40'(r4_p2ax);
            w_dy  = 40'(r4_p1ay) + 2 * 40'(r4_pxy2);
            w_dxs = lud_pkg::sat32(w_dx);
            w_dys = lud_pkg::sat32(w_dy);
            w_bad = (w_den <= 40'sd0);
            w_nx  = 33'(r4_s.x0) - 33'(w_dxs);
            w_ny  = 33'(r4_s.y0) - 33'(w_dys);
            w_mx  = w_nx[32] ? 33'(-w_nx) : 33'(w_nx);
            w_my  = w_ny[32] ? 33'(-w_ny) : 33'(w_ny);

            n_req.neg_x = w_nx[32];
            n_req.neg_y = w_ny[32];
            n_req.num_x = {w_mx, 28'b0};
            n_req.num_y = {w_my, 28'b0};
            n_req.den_x = w_bad ? lud_pkg::DEN_W'(1) : w_den[lud_pkg::DEN_W-1:0];
            n_req.den_y = n_req.den_x;
            n_req.side  = r4_s;
            n_req.side.flag = r4_s.flag || w_bad || lud_pkg::ovf32(w_dx)
                           || lud_pkg::ovf32(w_dy);
            n_req.side.done = r4_s.done || w_bad;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r1_v <= 1'b0;
                r2_v <= 1'b0;
                r3_v <= 1'b0;
                r4_v <= 1'b0;
                r5_v <= 1'b0;
            end else if (w_adv) begin
                r1_v <= w_rsp_v[p];
                r2_v <= r1_v;
                r3_v <= r2_v;
                r4_v <= r3_v;
                r5_v <= r4_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r1_s      <= n_s1;
                r1_xx     <= lud_pkg::sat32(40'(w_xx));
                r1_yy     <= lud_pkg::sat32(40'(w_yy));
                r1_xy     <= lud_pkg::sat32(40'(w_xy));

                r2_s      <= n_s2;
                r2_xx     <= r1_xx;
                r2_yy     <= r1_yy;
                r2_r2     <= lud_pkg::sat32(w_r2);
                r2_pxy1   <= lud_pkg::qmul(33'(r_p1), 33'(r1_xy));
                r2_pxy2   <= lud_pkg::qmul(33'(r_p2), 33'(r1_xy));

                r3_s      <= n_s3;
                r3_r4     <= lud_pkg::sat32(40'(w_r4));
                r3_ax     <= lud_pkg::sat32(w_ax);
                r3_ay     <= lud_pkg::sat32(w_ay);
                r3_k1r2   <= lud_pkg::qmul(33'(r_k1), 33'(r2_r2));
                r3_pxy1   <= r2_pxy1;
                r3_pxy2   <= r2_pxy2;

                r4_s      <= r3_s;
                r4_k1r2   <= r3_k1r2;
                r4_k2r4   <= lud_pkg::qmul(33'(r_k2), 33'(r3_r4));
                r4_p2ax   <= lud_pkg::qmul(33'(r_p2), 33'(r3_ax));
                r4_p1ay   <= lud_pkg::qmul(33'(r_p1), 33'(r3_ay));
                r4_pxy1   <= r3_pxy1;
                r4_pxy2   <= r3_pxy2;

                r5_req    <= n_req;
            end
        end

        assign w_req[p+1]   = r5_req;
        assign w_req_v[p+1] = r5_v;
    end

    // ---------------- back to pixels ----------------
    logic               r6_v;
    lud_pkg::t_side     r6_s;
    logic signed [36:0] r6_px, r6_py;
    logic signed [39:0] w_ox, w_oy;
    logic signed [31:0] r_out_x, r_out_y;
    logic               r_out_sat;

    assign w_ox = 40'(r6_px) + $signed({8'b0, r_cx});
    assign w_oy = 40'(r6_py) + $signed({8'b0, r_cy});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v    <= 1'b0;
            r_out_v <= 1'b0;
        end else if (w_adv) begin
            r6_v    <= w_rsp_v[ITER];
            r_out_v <= r6_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r6_s      <= w_cur[ITER];
            r6_px     <= lud_pkg::qmul(33'(w_cur[ITER].x), $signed({1'b0, r_fx}));
            r6_py     <= lud_pkg::qmul(33'(w_cur[ITER].y), $signed({1'b0, r_fy}));
            r_out_x   <= lud_pkg::sat32(w_ox);
            r_out_y   <= lud_pkg::sat32(w_oy);
            r_out_sat <= r6_s.flag || lud_pkg::ovf32(w_ox) || lud_pkg::ovf32(w_oy);
        end
    end

    assign o_res.valid       = r_out_v;
    assign o_res.corrected_x = r_out_x;
    assign o_res.corrected_y = r_out_y;
    assign o_res.saturated   = r_out_sat;

endmodule

`default_nettype wire

>>> rtl/core/lud_div.sv
// Pipelined two-lane restoring divider, one quotient bit per stage, saturating to s32.
// Depends on lud_pkg for the request/response structs.
`default_nettype none

module lud_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire lud_pkg::t_div_req i_req,
    output logic                   o_valid,
    output lud_pkg::t_div_rsp      o_rsp
);

    localparam int NST = lud_pkg::DIV_STEPS + 1;
    localparam int NW  = lud_pkg::NUM_W;
    localparam int DW  = lud_pkg::DEN_W;
    localparam int TW  = DW + lud_pkg::DIV_STEPS;   // shifted divisor width

    logic [NW-1:0]   w_num [2];
    logic [DW-1:0]   w_den [2];
    logic            w_neg [2];

    logic [NW-1:0]   r_rem [2][NST];
    logic [31:0]     r_q   [2][NST];
    logic [DW-1:0]   r_den [2][NST];
    logic            r_neg [2][NST];
    logic            r_ovf [2][NST];
    lud_pkg::t_side  r_side [NST];
    logic            r_v    [NST];

    logic [TW-1:0]   w_trial [2][NST];
    logic            w_take  [2][NST];
    logic signed [31:0] w_val [2];
    logic            w_sat [2];

    assign w_num[0] = i_req.num_x;
    assign w_num[1] = i_req.num_y;
    assign w_den[0] = i_req.den_x;
    assign w_den[1] = i_req.den_y;
    assign w_neg[0] = i_req.neg_x;
    assign w_neg[1] = i_req.neg_y;

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            w_trial[l][0] = '0;
            w_take[l][0]  = 1'b0;
            for (int s = 1; s < NST; s++) begin
                w_trial[l][s] = TW'(r_den[l][s-1]) << (lud_pkg::DIV_STEPS - s);
                w_take[l][s]  = TW'(r_rem[l][s-1]) >= w_trial[l][s];
            end
        end
    end

    // final sign and saturation
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            w_sat[l] = r_ovf[l][NST-1]
                    || (!r_neg[l][NST-1] && r_q[l][NST-1][31])
                    || (r_neg[l][NST-1] && (r_q[l][NST-1] > 32'h80000000));
            if (w_sat[l]) begin
                w_val[l] = r_neg[l][NST-1] ? 32'sh80000000 : 32'sh7fffffff;
            end else if (r_neg[l][NST-1]) begin
                w_val[l] = -r_q[l][NST-1];
            end else begin
                w_val[l] = r_q[l][NST-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NST; s++) begin
                r_v[s] <= 1'b0;
            end
            o_valid <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int s = 1; s < NST; s++) begin
                r_v[s] <= r_v[s-1];
            end
            o_valid <= r_v[NST-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_req.side;
            for (int s = 1; s < NST; s++) begin
                r_side[s] <= r_side[s-1];
            end
            for (int l = 0; l < 2; l++) begin
                r_rem[l][0] <= w_num[l];
                r_q[l][0]   <= '0;
                r_den[l][0] <= w_den[l];
                r_neg[l][0] <= w_neg[l];
                r_ovf[l][0] <= {w_den[l], 32'b0} <= TW'(w_num[l]);
                for (int s = 1; s < NST; s++) begin
                    r_den[l][s] <= r_den[l][s-1];
                    r_neg[l][s] <= r_neg[l][s-1];
                    r_ovf[l][s] <= r_ovf[l][s-1];
                    if (w_take[l][s]) begin
                        r_rem[l][s] <= r_rem[l][s-1] - w_trial[l][s][NW-1:0];
                        r_q[l][s]   <= r_q[l][s-1] | (32'd1 << (lud_pkg::DIV_STEPS - s));
                    end else begin
                        r_rem[l][s] <= r_rem[l][s-1];
                        r_q[l][s]   <= r_q[l][s-1];
                    end
                end
            end
            o_rsp.q_x   <= w_val[0];
            o_rsp.q_y   <= w_val[1];
            o_rsp.sat_x <= w_sat[0];
            o_rsp.sat_y <= w_sat[1];
            o_rsp.side  <= r_side[NST-1];
        end
    end

endmodule

`default_nettype wire

>>> tb/sv/lud_checker.sv
`timescale 1ns / 1ps
// Checker for the lens point undistorter: watches the point, result and config channels.
// Depends on lud_pkg and lud_if; predicts each corrected point and compares in order.
`default_nettype none

module lud_checker (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    lud_point_if      pt,
    lud_result_if     res,
    lud_cfg_if        cfg,
    output int        o_errors,
    output int        o_pending
);

    localparam longint ONE  = 64'sd268435456;
    localparam longint HALF = 64'sd134217728;
    localparam longint SMAX = 64'sd2147483647;
    localparam longint SMIN = -64'sd2147483648;

    typedef struct {
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic               sat;
    } t_corrected;

    t_corrected  corrected_q[$];
    logic [31:0] fx, fy, ctr_x, ctr_y;
    logic signed [31:0] k1, k2, p1, p2;
    int          req_seen;

    function automatic longint clip(longint v, inout bit f);
        if (v > SMAX) begin
            f = 1;
            return SMAX;
        end
        if (v < SMIN) begin
            f = 1;
            return SMIN;
        end
        return v;
    endfunction

    // round half up, then floor shift
    function automatic longint qprod(longint a, longint b);
        longint p;
        p = a * b + HALF;
        return p >>> 28;
    endfunction

    function automatic longint to_norm(longint p, longint c, longint f, inout bit fl);
        if (f == 0) begin
            fl = 1;
            return 0;
        end
        return clip(((p - c) * ONE) / f, fl);
    endfunction

    function automatic t_corrected undistort(logic signed [31:0] px, logic signed [31:0] py);
        t_corrected r;
        bit fl;
        longint x0, y0, x, y, xx, yy, xy, r2, r4, den, ax, ay, dx, dy;
        longint lfx, lfy, lcx, lcy;
        fl  = 0;
        lfx = longint'({32'b0, fx});
        lfy = longint'({32'b0, fy});
        lcx = longint'({32'b0, ctr_x});
        lcy = longint'({32'b0, ctr_y});
        x0  = to_norm(longint'(px), lcx, lfx, fl);
        y0  = to_norm(longint'(py), lcy, lfy, fl);
        x   = x0;
        y   = y0;
        for (int i = 0; i < lud_pkg::ITERATIONS; i++) begin
            xx  = clip(qprod(x, x), fl);
            yy  = clip(qprod(y, y), fl);
            xy  = clip(qprod(x, y), fl);
            r2  = clip(xx + yy, fl);
            r4  = clip(qprod(r2, r2), fl);
            den = ONE + qprod(longint'(k1), r2) + qprod(longint'(k2), r4);
            ax  = clip(r2 + 2 * xx, fl);
            ay  = clip(r2 + 2 * yy, fl);
            dx  = clip(2 * qprod(longint'(p1), xy) + qprod(longint'(p2), ax), fl);
            dy  = clip(qprod(longint'(p1), ay) + 2 * qprod(longint'(p2), xy), fl);
            if (den <= 0) begin
                fl = 1;
                break;
            end
            x = clip(((x0 - dx) * ONE) / den, fl);
            y = clip(((y0 - dy) * ONE) / den, fl);
        end
        r.cx  = 32'(clip(qprod(x, lfx) + lcx, fl));
        r.cy  = 32'(clip(qprod(y, lfy) + lcy, fl));
        r.sat = fl;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH result %0d %s: got %h expected %h", req_seen, what, got, want);
        o_errors++;
    endtask

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        t_corrected w;
        if (!i_rst_n) begin
            fx    <= 32'd36044800;
            fy    <= 32'd36044800;
            ctr_x <= 32'd20971520;
            ctr_y <= 32'd15728640;
            k1 <= '0;
            k2 <= '0;
            p1 <= '0;
            p2 <= '0;
            req_seen = 0;
            corrected_q.delete();
            o_pending <= 0;
        end else begin
            if (pt.valid && pt.ready) begin
                corrected_q.insert(corrected_q.size(), undistort(pt.point_x, pt.point_y));
            end
            if (res.valid && res.ready) begin
                if (corrected_q.size() == 0) begin
                    report_mismatch("with nothing outstanding", res.corrected_x, '0);
                end else begin
                    w = corrected_q.pop_front();
                    if (res.corrected_x !== w.cx)
                        report_mismatch("corrected_x", res.corrected_x, w.cx);
                    if (res.corrected_y !== w.cy)
                        report_mismatch("corrected_y", res.corrected_y, w.cy);
                    if (res.saturated !== w.sat)
                        report_mismatch("saturated", 32'(res.saturated), 32'(w.sat));
                end
                req_seen++;
            end
            o_pending <= corrected_q.size();
            if (cfg.valid && cfg.ready) begin
                case (lud_pkg::t_cfg_idx'(cfg.index))
                    lud_pkg::CFG_FOCAL_X:   fx    <= cfg.data;
                    lud_pkg::CFG_FOCAL_Y:   fy    <= cfg.data;
                    lud_pkg::CFG_CENTER_X:  ctr_x <= cfg.data;
                    lud_pkg::CFG_CENTER_Y:  ctr_y <= cfg.data;
                    lud_pkg::CFG_RADIAL_K1: k1    <= cfg.data;
                    lud_pkg::CFG_RADIAL_K2: k2    <= cfg.data;
                    lud_pkg::CFG_TANG_P1:   p1    <= cfg.data;
                    lud_pkg::CFG_TANG_P2:   p2    <= cfg.data;
                    default: ;
                endcase
            end
        end
    end

endmodule

`default_nettype wire

>>> tb/sv/lens_undistort_point_test.sv
`timescale 1ns / 1ps
// Top of the lens point undistorter test: clock, reset, config phases and point stimulus.
// Depends on lud_pkg, lud_if, lens_undistort_point and lud_checker.
`default_nettype none

module lens_undistort_point_test;

    localparam int LIMIT  = 600000;
    localparam int LAT    = 240;
    localparam int PHASES = 12;

    logic i_clk;
    logic i_rst_n;
    int   cycles;
    int   errors;
    int   pending;
    int   points_sent;
    bit   calm;
    bit   hold_req;

    lud_point_if  pt();
    lud_result_if res();
    lud_cfg_if    cfg();

    lens_undistort_point u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_pt   (pt),
        .o_res  (res),
        .i_cfg  (cfg)
    );

    lud_checker u_chk (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .pt       (pt),
        .res      (res),
        .cfg      (cfg),
        .o_errors (errors),
        .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    // result side: random stall bursts, one long hold-off on request
    initial begin
        res.ready = 0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_req) begin
                res.ready <= 0;
                repeat (600) @(posedge i_clk);
                hold_req = 0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                res.ready <= 0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
            end else begin
                res.ready <= 1;
                @(posedge i_clk);
            end
        end
    end

    task automatic write_reg(lud_pkg::t_cfg_idx idx, logic [31:0] data);
        cfg.valid <= 1;
        cfg.index <= idx;
        cfg.data  <= data;
        do @(posedge i_clk); while (!cfg.ready);
        cfg.valid <= 0;
        @(posedge i_clk);
    endtask

    task automatic write_all(logic [31:0] v [8]);
        for (int i = 0; i < 8; i++) write_reg(lud_pkg::t_cfg_idx'(i), v[i]);
    endtask

    task automatic send_point(logic [31:0] x, logic [31:0] y);
        if (!calm && $urandom_range(0, 4) == 0) begin
            pt.valid <= 0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        pt.valid   <= 1;
        pt.point_x <= x;
        pt.point_y <= y;
        do @(posedge i_clk); while (!pt.ready);
        points_sent++;
    endtask

    task automatic drain();
        pt.valid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (LAT) @(posedge i_clk);
    endtask

    function automatic logic [31:0] coeff();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 1 << 26)) - (1 << 25));
            default: return 32'($signed($urandom_range(0, 1 << 28)) - (1 << 27));
        endcase
    endfunction

    // mostly points near the image, some anywhere
    function automatic logic [31:0] coord();
        if ($urandom_range(0, 4) == 0) return $urandom;
        return $urandom_range(0, 32'h0400_0000) - 32'h0100_0000;
    endfunction

    initial begin
        logic [31:0] regs [8];
        int n;
        cycles      = 0;
        points_sent = 0;
        calm        = 0;
        hold_req    = 0;
        i_rst_n     = 0;
        pt.valid    = 0;
        pt.point_x  = '0;
        pt.point_y  = '0;
        cfg.valid   = 0;
        cfg.index   = '0;
        cfg.data    = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // reset settings, extremes of the point fields
        send_point(32'h0, 32'h0);
        send_point(32'h7fff_ffff, 32'h7fff_ffff);
        send_point(32'h8000_0000, 32'h8000_0000);
        send_point(32'h8000_0000, 32'h7fff_ffff);
        send_point(32'h0140_0000, 32'h00f0_0000);
        send_point(32'hffff_ffff, 32'h0000_0001);
        drain();

        // focal of 1.0, zero center, realistic distortion
        regs = '{32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0,
                 32'hfc00_0000, 32'h0100_0000, 32'h0010_0000, 32'hfff0_0000};
        write_all(regs);
        send_point(32'h0, 32'h0);
        send_point(32'h0001_0000, 32'hffff_0000);
        send_point(32'h7fff_ffff, 32'h8000_0000);
        send_point(32'h0000_8000, 32'h0000_4000);
        drain();

        // largest focal and center, coefficient extremes (denominator goes negative)
        regs = '{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000};
        write_all(regs);
        send_point(32'h8000_0000, 32'h8000_0000);
        send_point(32'h7fff_ffff, 32'h0);
        send_point(32'h0, 32'h7fff_ffff);
        drain();

        // zero focal lengths
        regs = '{32'h0, 32'h0, 32'h0140_0000, 32'h00f0_0000,
                 32'h7fff_ffff, 32'h7fff_ffff, 32'h0, 32'h0};
        write_all(regs);
        send_point(32'h0200_0000, 32'h0100_0000);
        send_point(32'h8000_0000, 32'h7fff_ffff);
        drain();
        write_reg(lud_pkg::CFG_FOCAL_Y, 32'h0226_0000);
        send_point(32'h0100_0000, 32'h0300_0000);
        drain();

        for (int ph = 0; ph < PHASES; ph++) begin
            regs[0] = ($urandom_range(0, 7) == 0) ? $urandom
                                                  : $urandom_range(32'h0010_0000, 32'h0800_0000);
            regs[1] = ($urandom_range(0, 7) == 0) ? $urandom
                                                  : $urandom_range(32'h0010_0000, 32'h0800_0000);
            regs[2] = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 32'h0300_0000);
            regs[3] = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 32'h0300_0000);
            for (int i = 4; i < 8; i++) regs[i] = coeff();
            write_all(regs);
            calm = (ph == PHASES - 1);
            n    = 120;
            for (int i = 0; i < n; i++) begin
                if (ph == 2 && i == 10) hold_req = 1;
                send_point(coord(), coord());
            end
            drain();
        end

        $display("Sent %0d points over %0d register settings, incl. zero focal,",
                 points_sent, PHASES + 4);
        $display("non-positive denominators, saturation and a long output hold-off.");
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

`default_nettype wire
